@@ hdl/fctsf_pkg.sv @@
// Shared types, constants and arithmetic helpers of the stencil filter.
`default_nettype none
package fctsf_pkg;

    localparam int DATA_W          = 32;
    localparam int COEF_W          = 16;
    localparam int PCOLS_W         = 11;
    localparam int PROWS_W         = 13;
    localparam int ROW_W           = 12;
    localparam int MIN_DIM         = 5;
    localparam int ROW_LIMIT       = 4096;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int BUF_ROWS        = 4;
    localparam int SLOT_W          = 2;
    localparam int ENTRY_W         = BUF_ROWS * DATA_W;
    localparam int ADDR_W          = 4;

    typedef enum logic [1:0] {
        REG_KIND = 2'd0,
        REG_COEF = 2'd1,
        REG_COLS = 2'd2,
        REG_ROWS = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_DIFFUSE = 1'b0,
        KIND_ANTI    = 1'b1
    } kind_t;

    typedef struct packed {
        logic               neg;
        logic [32:0]        mag;
        logic signed [33:0] lim;
    } face_t;

    function automatic logic signed [31:0] get_slot(input logic [ENTRY_W-1:0] entry,
                                                    input logic [SLOT_W-1:0] slot);
        return $signed(entry[slot*DATA_W +: DATA_W]);
    endfunction

    function automatic face_t face_prep(input logic signed [31:0] m2,
                                        input logic signed [31:0] m1,
                                        input logic signed [31:0] p1,
                                        input logic signed [31:0] p2);
        logic signed [33:0] delm;
        logic signed [33:0] del;
        logic signed [33:0] delp;
        logic signed [33:0] sdm;
        logic signed [33:0] sdp;
        logic signed [33:0] amag;
        face_t              f;
        delm  = 34'(m1) - 34'(m2);
        del   = 34'(p1) - 34'(m1);
        delp  = 34'(p2) - 34'(p1);
        f.neg = del[33];
        amag  = f.neg ? -del : del;
        sdm   = f.neg ? -delm : delm;
        sdp   = f.neg ? -delp : delp;
        f.mag = amag[32:0];
        f.lim = (sdm < sdp) ? sdm : sdp;
        return f;
    endfunction

    function automatic logic signed [35:0] face_flux(input logic neg,
                                                     input logic [32:0] mm,
                                                     input logic signed [33:0] lim);
        logic signed [35:0] a;
        logic signed [35:0] b;
        logic signed [35:0] r;
        a = $signed({3'b000, mm});
        b = 36'(lim);
        r = (a < b) ? a : b;
        if (r < 0) begin
            r = '0;
        end
        return neg ? -r : r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] q;
        if (v > 40'sd2147483647) begin
            q = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            q = 32'h8000_0000;
        end else begin
            q = v[31:0];
        end
        return q;
    endfunction

endpackage
`default_nettype wire

@@ hdl/fctsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fctsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output      logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/fct_stencil_filter.sv @@
// Top level of the flux-corrected-transport stencil filter.
// Grid samples (signed Q16.16) enter on the s_ channel in raster order, ghost
// layers included, one item per cycle at most. Interior cells leave on the m_
// channel as filtered Q16.16 values, m_tlast marking the final cell of a grid.
// Settings are written through the APB port; the user must do so only while the block is idle (not enforced).
// A column-organised line store holds the last four rows: each entry keeps one
// column of all four rows, so a single RAM read per item, prefetched two
// columns ahead, plus a four-entry tap line supplies the whole cross stencil.
// Throughput: one item per cycle while the receiver does not stall the pipeline;
// after any register write no item is accepted while the prefetch is reloaded
// for the geometry in use.
// Reset clears counters, pipeline and registers; the first item is taken once
// the prefetch has been loaded after reset is released.
// When the receiver stalls, the four-stage pipeline fills and keeps accepting
// ghost-cell items and interior items until every stage holds a result.
`default_nettype none
module fct_stencil_filter #(
    parameter int MAX_COLUMNS = fctsf_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fctsf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output      logic [31:0]                    prdata,
    output      logic                           pready,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [31:0]                    s_tdata,   // sample
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [31:0]                    m_tdata,   // filtered
    output      logic                           m_tlast
);

    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int UCW = $clog2(MAX_COLUMNS + 1);
    localparam int GW  = ((UCW > fctsf_pkg::PCOLS_W) ? UCW : fctsf_pkg::PCOLS_W) + 2;
    localparam int EW  = fctsf_pkg::ENTRY_W;
    localparam int RW  = fctsf_pkg::PROWS_W;

    // configuration
    logic                           kind_reg;
    logic [fctsf_pkg::COEF_W-1:0]   coef_reg;
    logic [fctsf_pkg::PCOLS_W-1:0]  pcols_reg;
    logic [fctsf_pkg::PROWS_W-1:0]  prows_reg;
    logic [1:0]                     prime_reg;
    logic                           cfg_wr;
    fctsf_pkg::reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = fctsf_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= 1'b0;
            coef_reg  <= '0;
            pcols_reg <= fctsf_pkg::PCOLS_W'(fctsf_pkg::MIN_DIM);
            prows_reg <= fctsf_pkg::PROWS_W'(fctsf_pkg::MIN_DIM);
            prime_reg <= 2'd3;
        end else begin
            if (cfg_wr) begin
                prime_reg <= 2'd3;
            end else if (prime_reg != 2'd0) begin
                prime_reg <= prime_reg - 2'd1;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    fctsf_pkg::REG_KIND: kind_reg  <= pwdata[0];
                    fctsf_pkg::REG_COEF: coef_reg  <= pwdata[fctsf_pkg::COEF_W-1:0];
                    fctsf_pkg::REG_COLS: pcols_reg <= pwdata[fctsf_pkg::PCOLS_W-1:0];
                    fctsf_pkg::REG_ROWS: prows_reg <= pwdata[fctsf_pkg::PROWS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            fctsf_pkg::REG_KIND: prdata = {31'd0, kind_reg};
            fctsf_pkg::REG_COEF: prdata = 32'(coef_reg);
            fctsf_pkg::REG_COLS: prdata = 32'(pcols_reg);
            fctsf_pkg::REG_ROWS: prdata = 32'(prows_reg);
            default:             prdata = '0;
        endcase
    end

    // geometry in use
    logic [GW-1:0] cols;
    logic [RW-1:0] rows;

    always_comb begin
        cols = GW'(pcols_reg);
        if (cols < GW'(fctsf_pkg::MIN_DIM)) begin
            cols = GW'(fctsf_pkg::MIN_DIM);
        end else if (cols > GW'(MAX_COLUMNS)) begin
            cols = GW'(MAX_COLUMNS);
        end
        rows = prows_reg;
        if (rows < RW'(fctsf_pkg::MIN_DIM)) begin
            rows = RW'(fctsf_pkg::MIN_DIM);
        end else if (rows > RW'(fctsf_pkg::ROW_LIMIT)) begin
            rows = RW'(fctsf_pkg::ROW_LIMIT);
        end
    end

    // raster counters and handshake
    logic [CW-1:0]                 col_reg, col_next, col_adv;
    logic [fctsf_pkg::ROW_W-1:0]   row_reg, row_next, row_adv;
    logic [GW-1:0]                 colx, nx1, nx2;
    logic [RW-1:0]                 rowx;
    logic [CW-1:0]                 raddr;
    logic                          acc, emit, last;
    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic                          rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1 && (prime_reg == 2'd0);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        colx = GW'(col_reg);
        rowx = RW'(row_reg);
        emit = (rowx >= RW'(4)) && (rowx < rows) && (colx >= GW'(2))
               && (colx + GW'(3) <= cols);
        last = (rowx + RW'(1) == rows) && (colx + GW'(3) == cols);
        if (colx + GW'(1) >= cols) begin
            col_adv = '0;
            row_adv = (rowx + RW'(1) >= rows) ? '0 : row_reg + 1'b1;
        end else begin
            col_adv = col_reg + 1'b1;
            row_adv = row_reg;
        end
        col_next = acc ? col_adv : col_reg;
        row_next = acc ? row_adv : row_reg;
        nx1 = (GW'(col_next) + GW'(1) >= cols) ? '0 : GW'(col_next) + GW'(1);
        nx2 = (nx1 + GW'(1) >= cols) ? '0 : nx1 + GW'(1);
    end

    always_comb begin
        if (prime_reg == 2'd3) begin
            raddr = col_reg;
        end else if (prime_reg == 2'd2) begin
            raddr = nx1[CW-1:0];
        end else begin
            raddr = nx2[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store: one entry per column, one slot per buffered row
    logic [EW-1:0] ram_rdata;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] tap_reg [4];
    logic [fctsf_pkg::SLOT_W-1:0] rs;

    assign rs = row_reg[fctsf_pkg::SLOT_W-1:0];

    always_comb begin
        ram_wdata = tap_reg[2];
        ram_wdata[rs*fctsf_pkg::DATA_W +: fctsf_pkg::DATA_W] = s_tdata;
    end

    fctsf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (acc),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (acc) begin
            tap_reg[0] <= tap_reg[1];
            tap_reg[1] <= tap_reg[2];
            tap_reg[2] <= tap_reg[3];
            tap_reg[3] <= ram_rdata;
        end else if (prime_reg == 2'd2 || prime_reg == 2'd1) begin
            tap_reg[2] <= tap_reg[3];
            tap_reg[3] <= ram_rdata;
        end
    end

    // stage 1: gather the cross stencil
    logic signed [31:0] w_reg [9];
    logic               kind1_reg, last1_reg;
    logic [fctsf_pkg::SLOT_W-1:0] sc;

    assign sc = rs - 2'd2;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            w_reg[0]  <= fctsf_pkg::get_slot(tap_reg[0], sc);
            w_reg[1]  <= fctsf_pkg::get_slot(tap_reg[1], sc);
            w_reg[2]  <= fctsf_pkg::get_slot(tap_reg[2], sc);
            w_reg[3]  <= fctsf_pkg::get_slot(tap_reg[3], sc);
            w_reg[4]  <= fctsf_pkg::get_slot(ram_rdata, sc);
            w_reg[5]  <= fctsf_pkg::get_slot(tap_reg[2], rs);
            w_reg[6]  <= fctsf_pkg::get_slot(tap_reg[2], rs + 2'd1);
            w_reg[7]  <= fctsf_pkg::get_slot(tap_reg[2], rs + 2'd3);
            w_reg[8]  <= $signed(s_tdata);
            kind1_reg <= kind_reg;
            last1_reg <= last;
        end
    end

    // stage 2: differences and limits
    logic signed [34:0] lap2_reg;
    logic signed [31:0] ctr2_reg;
    fctsf_pkg::face_t   f2_reg [4];
    logic               kind2_reg, last2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            lap2_reg  <= 35'(w_reg[1]) + 35'(w_reg[3]) + 35'(w_reg[6]) + 35'(w_reg[7])
                         - (35'(w_reg[2]) <<< 2);
            ctr2_reg  <= w_reg[2];
            f2_reg[0] <= fctsf_pkg::face_prep(w_reg[0], w_reg[1], w_reg[2], w_reg[3]);
            f2_reg[1] <= fctsf_pkg::face_prep(w_reg[1], w_reg[2], w_reg[3], w_reg[4]);
            f2_reg[2] <= fctsf_pkg::face_prep(w_reg[5], w_reg[6], w_reg[2], w_reg[7]);
            f2_reg[3] <= fctsf_pkg::face_prep(w_reg[6], w_reg[2], w_reg[7], w_reg[8]);
            kind2_reg <= kind1_reg;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: products with mu
    logic [48:0]        mp [4];
    logic signed [51:0] lp;
    logic [32:0]        mm3_reg [4];
    logic signed [33:0] lim3_reg [4];
    logic               neg3_reg [4];
    logic signed [35:0] mlap3_reg;
    logic signed [31:0] ctr3_reg;
    logic               kind3_reg, last3_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mp[i] = 49'(f2_reg[i].mag) * 49'(coef_reg);
        end
        lp = 52'(lap2_reg) * $signed({36'd0, coef_reg});
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            for (int i = 0; i < 4; i++) begin
                mm3_reg[i]  <= mp[i][48:16];
                lim3_reg[i] <= f2_reg[i].lim;
                neg3_reg[i] <= f2_reg[i].neg;
            end
            mlap3_reg <= lp[51:16];
            ctr3_reg  <= ctr2_reg;
            kind3_reg <= kind2_reg;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: limit, sum, saturate into the output register
    logic signed [35:0] fl [4];
    logic signed [39:0] vsum;
    logic [31:0]        out_reg;
    logic               tlast_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fl[i] = fctsf_pkg::face_flux(neg3_reg[i], mm3_reg[i], lim3_reg[i]);
        end
        if (fctsf_pkg::kind_t'(kind3_reg) == fctsf_pkg::KIND_DIFFUSE) begin
            vsum = 40'(ctr3_reg) + 40'(mlap3_reg);
        end else begin
            vsum = 40'(ctr3_reg) + 40'(fl[0]) + 40'(fl[2]) - 40'(fl[1]) - 40'(fl[3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            out_reg   <= fctsf_pkg::sat32(vsum);
            tlast_reg <= last3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= acc && emit;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = tlast_reg;

    a_emit_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && emit) |=> v1_reg)
        else $error("interior item did not enter the pipeline");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_tready)
        else $error("item accepted right after a register write");

    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready) |-> !s_tready)
        else $error("item accepted into a full pipeline");

endmodule
`default_nettype wire

@@ tb/sv/tb_fct_stencil_filter.sv @@
// Self-checking testbench of the stencil filter: random raster frames, predicted results.
`timescale 1ns / 1ps
module tb_fct_stencil_filter;

    localparam int MAXC = 1024;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // filtered
    logic        m_tlast;

    fct_stencil_filter dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [31:0] pend_samples[$];
    logic [32:0] cell_expect[$];
    int          fails = 0;
    bit          quiet = 0;
    int          stall_req = 0;
    int          stall_seen = 0;
    longint      cycles = 0;

    // predictor state
    fctsf_pkg::kind_t kind_m = fctsf_pkg::KIND_DIFFUSE;
    int          mu_m = 0;
    int          pcols_m = 5;
    int          prows_m = 5;
    int          lines [4][MAXC];
    int          col_m = 0;
    int          row_m = 0;

    function automatic longint mul_mu(longint x);
        return (x * longint'(mu_m)) >>> 16;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint flux(longint m2, longint m1, longint p1, longint p2);
        longint d;
        longint s;
        longint r;
        d = p1 - m1;
        s = d >= 0 ? 1 : -1;
        r = lmin(mul_mu(d >= 0 ? d : -d), lmin(s * (m1 - m2), s * (p2 - p1)));
        if (r < 0) r = 0;
        return s * r;
    endfunction

    function automatic longint line_at(int back, int c);
        return longint'(lines[(row_m + 4 - back % 4) % 4][c % MAXC]);
    endfunction

    function automatic void filter_cell(logic [31:0] smp);
        int cols;
        int rows;
        longint w[9];
        longint v;
        cols = pcols_m < 5 ? 5 : (pcols_m > MAXC ? MAXC : pcols_m);
        rows = prows_m < 5 ? 5 :
               (prows_m > fctsf_pkg::ROW_LIMIT ? fctsf_pkg::ROW_LIMIT : prows_m);
        if (row_m >= 4 && row_m < rows && col_m >= 2 && col_m + 3 <= cols) begin
            for (int k = 0; k < 5; k++) w[k] = line_at(2, col_m - 2 + k);
            w[5] = line_at(4, col_m);
            w[6] = line_at(3, col_m);
            w[7] = line_at(1, col_m);
            w[8] = longint'($signed(smp));
            if (kind_m == fctsf_pkg::KIND_DIFFUSE) begin
                v = w[2] + mul_mu(w[1] + w[3] + w[6] + w[7] - 4 * w[2]);
            end else begin
                v = w[2] + flux(w[0], w[1], w[2], w[3]) + flux(w[5], w[6], w[2], w[7])
                    - flux(w[1], w[2], w[3], w[4]) - flux(w[6], w[2], w[7], w[8]);
            end
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            cell_expect.push_back({(row_m + 1 == rows && col_m + 3 == cols), v[31:0]});
        end
        lines[row_m % 4][col_m] = smp;
        if (col_m + 1 >= cols) begin
            col_m = 0;
            row_m = (row_m + 1 >= rows) ? 0 : row_m + 1;
        end else begin
            col_m++;
        end
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) filter_cell(s_tdata);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pend_samples.size() > 0) begin
                s_tdata <= pend_samples.pop_front();
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 16);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    int recv_gap = 0;
    int long_hold = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cell_expect.size() == 0) begin
                $display("%0t: unexpected item data=%h last=%b", $time, m_tdata, m_tlast);
                fails++;
            end else begin
                logic [32:0] e;
                e = cell_expect.pop_front();
                if (m_tdata !== e[31:0] || m_tlast !== e[32]) begin
                    $display("%0t: mismatch expected data=%h last=%b actual data=%h last=%b",
                             $time, e[31:0], e[32], m_tdata, m_tlast);
                    fails++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            long_hold <= 400;
            m_tready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 19) == 0) recv_gap <= $urandom_range(1, 16);
        end
    end

    task automatic reg_write(fctsf_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            fctsf_pkg::REG_KIND: kind_m = fctsf_pkg::kind_t'(val[0]);
            fctsf_pkg::REG_COEF: mu_m = val[15:0];
            fctsf_pkg::REG_COLS: pcols_m = val[10:0];
            fctsf_pkg::REG_ROWS: prows_m = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pend_samples.size() > 0 || s_tvalid || cell_expect.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic setup(fctsf_pkg::kind_t k, int mu, int pc, int pr);
        drain();
        reg_write(fctsf_pkg::REG_KIND, k);
        reg_write(fctsf_pkg::REG_COEF, mu);
        reg_write(fctsf_pkg::REG_COLS, pc);
        reg_write(fctsf_pkg::REG_ROWS, pr);
    endtask

    function automatic logic [31:0] pick_sample(int style, int base);
        case (style)
            0: return $urandom();
            1: case ($urandom_range(0, 4))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0;
                   3: return 32'hFFFF_FFFF;
                   default: return 32'h1;
               endcase
            default: return base + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    task automatic queue_frames(int nframes, int style);
        int cols;
        int rows;
        int base;
        cols = pcols_m < 5 ? 5 : (pcols_m > MAXC ? MAXC : pcols_m);
        rows = prows_m < 5 ? 5 :
               (prows_m > fctsf_pkg::ROW_LIMIT ? fctsf_pkg::ROW_LIMIT : prows_m);
        base = $urandom_range(0, 1 << 22) - (1 << 21);
        for (int f = 0; f < nframes; f++)
            for (int i = 0; i < cols * rows; i++) begin
                pend_samples.push_back(pick_sample(style, base));
                if (style == 2 && $urandom_range(0, 7) == 0) base += $urandom_range(0, 1 << 20) - (1 << 19);
            end
    endtask

    initial begin
        int sent;
        int st;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes on the smallest grid, both kinds, then other data on grids one column or row larger
        setup(fctsf_pkg::KIND_DIFFUSE, 16'hFFFF, 5, 5);
        queue_frames(1, 1);
        setup(fctsf_pkg::KIND_ANTI, 16'hFFFF, 5, 5);
        queue_frames(1, 1);
        setup(fctsf_pkg::KIND_ANTI, 0, 6, 5);
        queue_frames(1, 2);
        setup(fctsf_pkg::KIND_DIFFUSE, 0, 5, 6);
        queue_frames(1, 0);

        // geometry below range on both registers
        setup(fctsf_pkg::KIND_ANTI, 16'h8000, 2, 0);
        queue_frames(1, 2);
        setup(fctsf_pkg::KIND_DIFFUSE, 16'h4000, 0, 4);
        queue_frames(1, 2);

        sent = 0;
        while (sent < 1450) begin
            setup(fctsf_pkg::kind_t'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 65535),
                  $urandom_range(5, 12), $urandom_range(5, 10));
            if (sent > 1150) quiet = 1;
            st = $urandom_range(0, 5);
            st = st < 4 ? 2 : (st == 4 ? 0 : 1);
            queue_frames($urandom_range(1, 3), st);
            sent += pend_samples.size();
            if (stall_req < 2 && sent > 400 * (stall_req + 1)) stall_req++;
        end
        drain();

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
